// ===== rtl/boc_pkg.sv =====
// boc_pkg: shared types and constants of the object identifier content codec
`default_nettype none
package boc_pkg;

   localparam int BOC_FIRST_RADIX = 40;   // first octet carries first*40+second
   localparam int BOC_FIRST_MAX   = 2;    // first arc is clamped to this
   localparam int BOC_GROUP_BITS  = 7;    // payload bits per content octet
   localparam int BOC_MAX_GROUPS  = 6;    // octets for one arc, widest case
   localparam int BOC_IDX_W       = 3;    // counts results of one request

   localparam logic BOC_FUNC_DECODE = 1'b0;
   localparam logic BOC_FUNC_ENCODE = 1'b1;

   typedef enum logic [1:0] {
      BOC_OK    = 2'd0,
      BOC_TRUNC = 2'd1,
      BOC_OVF   = 2'd2
   } boc_status_type;

   typedef struct packed {
      logic        func;
      logic [7:0]  data_byte;
      logic [31:0] arc_in;
      logic        in_last;
   } boc_req_type;

   typedef struct packed {
      logic [31:0]    arc_out;
      logic [7:0]     byte_out;
      logic           run_last;
      logic           oid_end;
      boc_status_type status;
   } boc_rsp_type;

   // results of one request, sent from the highest index down to index 0
   typedef struct packed {
      logic                                              is_enc;
      logic                                              last;
      boc_status_type                                    status;
      logic [BOC_IDX_W-1:0]                              top_idx;
      logic [31:0]                                       arc_hi;
      logic [31:0]                                       arc_lo;
      logic [BOC_MAX_GROUPS-1:0][BOC_GROUP_BITS-1:0]     groups;
   } boc_batch_type;

endpackage
`default_nettype wire

// ===== rtl/boc_core.sv =====
// boc_core: decode and encode state with the per-request result logic
`default_nettype none
module boc_core #(
   parameter int ARC_BITS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire boc_pkg::boc_req_type item,
   output logic                      produce,
   output boc_pkg::boc_batch_type    batch
);
   import boc_pkg::*;

   localparam int HW  = (ARC_BITS < 32) ? ARC_BITS : 32;
   localparam int VXW = HW + 6;
   localparam int VW  = (ARC_BITS < VXW) ? ARC_BITS : VXW;
   localparam int GW  = BOC_MAX_GROUPS * BOC_GROUP_BITS;

   logic                dec_started_ff, dec_started_in;
   logic [ARC_BITS-1:0] acc_ff, acc_in;
   logic                ovf_ff, ovf_in;
   logic                enc_first_ff, enc_first_in;
   logic [HW-1:0]       held_ff, held_in;
   logic                enc_second_ff, enc_second_in;

   logic [7:0]          b;
   logic [1:0]          a0;
   logic [7:0]          a1;
   logic [ARC_BITS-1:0] acc_shift;
   logic                ovf_any;
   logic [HW-1:0]       arc_m;
   logic [VXW-1:0]      v_full;
   logic                enc_ovf;
   logic [VW-1:0]       v;
   logic [GW-1:0]       v_pad;
   logic [BOC_IDX_W-1:0] n_top;

   assign b = item.data_byte;

   always_comb begin
      if (b >= 8'(BOC_FIRST_MAX * BOC_FIRST_RADIX)) begin
         a0 = 2'(BOC_FIRST_MAX);
         a1 = b - 8'(BOC_FIRST_MAX * BOC_FIRST_RADIX);
      end else if (b >= 8'(BOC_FIRST_RADIX)) begin
         a0 = 2'd1;
         a1 = b - 8'(BOC_FIRST_RADIX);
      end else begin
         a0 = 2'd0;
         a1 = b;
      end
   end

   assign acc_shift = {acc_ff[ARC_BITS-8:0], b[6:0]};
   assign ovf_any   = ovf_ff | (|acc_ff[ARC_BITS-1:ARC_BITS-7]);

   assign arc_m   = item.arc_in[HW-1:0];
   // times 40 as times 32 plus times 8
   assign v_full  = (VXW'(held_ff) << 5) + (VXW'(held_ff) << 3) + VXW'(arc_m);
   assign enc_ovf = |(v_full >> ARC_BITS);
   assign v       = enc_second_ff ? VW'(arc_m) : VW'(v_full);
   assign v_pad   = GW'(v);

   // highest nonzero group sets the octet count, at least one octet
   always_comb begin
      n_top = '0;
      for (int g = 1; g < BOC_MAX_GROUPS; g++) begin
         if (v_pad[g*BOC_GROUP_BITS +: BOC_GROUP_BITS] != '0) begin
            n_top = BOC_IDX_W'(g);
         end
      end
   end

   always_comb begin
      dec_started_in = dec_started_ff;
      acc_in         = acc_ff;
      ovf_in         = ovf_ff;
      enc_first_in   = enc_first_ff;
      held_in        = held_ff;
      enc_second_in  = enc_second_ff;
      produce        = 1'b0;
      batch          = '0;
      batch.last     = item.in_last;
      for (int g = 0; g < BOC_MAX_GROUPS; g++) begin
         batch.groups[g] = v_pad[g*BOC_GROUP_BITS +: BOC_GROUP_BITS];
      end
      case (item.func)
         BOC_FUNC_DECODE: begin
            if (!dec_started_ff) begin
               produce        = 1'b1;
               batch.top_idx  = BOC_IDX_W'(1);
               batch.arc_hi   = 32'(a0);
               batch.arc_lo   = 32'(a1);
               dec_started_in = !item.in_last;
               acc_in         = '0;
               ovf_in         = 1'b0;
            end else begin
               acc_in = acc_shift;
               ovf_in = ovf_any;
               if (!b[7]) begin
                  produce      = 1'b1;
                  batch.arc_lo = 32'(acc_shift);
                  batch.status = ovf_any ? BOC_OVF : BOC_OK;
                  acc_in       = '0;
                  ovf_in       = 1'b0;
                  if (item.in_last) begin
                     dec_started_in = 1'b0;
                  end
               end else if (item.in_last) begin
                  // content ends inside a subidentifier
                  produce        = 1'b1;
                  batch.status   = BOC_TRUNC;
                  dec_started_in = 1'b0;
                  acc_in         = '0;
                  ovf_in         = 1'b0;
               end
            end
         end
         BOC_FUNC_ENCODE: begin
            if (!enc_first_ff) begin
               held_in       = arc_m;
               enc_first_in  = !item.in_last;
               enc_second_in = 1'b0;
            end else begin
               produce       = 1'b1;
               batch.is_enc  = 1'b1;
               batch.top_idx = n_top;
               batch.status  = (!enc_second_ff && enc_ovf) ? BOC_OVF : BOC_OK;
               enc_second_in = 1'b1;
               if (item.in_last) begin
                  enc_first_in  = 1'b0;
                  enc_second_in = 1'b0;
                  held_in       = '0;
               end
            end
         end
         default: begin
            produce = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_started_ff <= 1'b0;
         acc_ff         <= '0;
         ovf_ff         <= 1'b0;
         enc_first_ff   <= 1'b0;
         held_ff        <= '0;
         enc_second_ff  <= 1'b0;
      end else if (step) begin
         dec_started_ff <= dec_started_in;
         acc_ff         <= acc_in;
         ovf_ff         <= ovf_in;
         enc_first_ff   <= enc_first_in;
         held_ff        <= held_in;
         enc_second_ff  <= enc_second_in;
      end
   end

   // a partial arc only exists once the first octet is consumed
   a_acc_needs_start: assert property (@(posedge clock) disable iff (reset)
      !dec_started_ff |-> (acc_ff == '0) && !ovf_ff)
      else $error("partial arc held while decoder expects first octet");

   a_second_needs_first: assert property (@(posedge clock) disable iff (reset)
      enc_second_ff |-> enc_first_ff)
      else $error("second arc marked sent without a held first arc");

endmodule
`default_nettype wire

// ===== rtl/boc_emit.sv =====
// boc_emit: result register that sends the results of one request in turn
`default_nettype none
module boc_emit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load,
   input  wire boc_pkg::boc_batch_type batch,
   input  wire logic                   rsp_stall,
   output logic                        ready,
   output logic                        rsp_valid,
   output boc_pkg::boc_rsp_type        rsp_data
);
   import boc_pkg::*;

   logic                 busy_ff, busy_in;
   logic [BOC_IDX_W-1:0] idx_ff, idx_in;
   boc_batch_type        batch_ff, batch_in;
   logic                 fire;
   logic                 final_one;

   assign fire      = busy_ff && !rsp_stall;
   assign final_one = (idx_ff == '0);
   assign ready     = !busy_ff || (final_one && !rsp_stall);
   assign rsp_valid = busy_ff;

   always_comb begin
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      batch_in = batch_ff;
      if (fire) begin
         if (final_one) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff - BOC_IDX_W'(1);
         end
      end
      if (load) begin
         busy_in  = 1'b1;
         idx_in   = batch.top_idx;
         batch_in = batch;
      end
   end

   always_comb begin
      rsp_data          = '0;
      rsp_data.run_last = final_one;
      rsp_data.oid_end  = final_one && batch_ff.last;
      rsp_data.status   = batch_ff.status;
      if (batch_ff.is_enc) begin
         // continuation bit on all but the closing octet
         rsp_data.byte_out = {!final_one, batch_ff.groups[idx_ff]};
      end else begin
         rsp_data.arc_out = final_one ? batch_ff.arc_lo : batch_ff.arc_hi;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      batch_ff <= batch_in;
   end

   a_load_when_ready: assert property (@(posedge clock) disable iff (reset)
      load |-> ready)
      else $error("new results loaded over results still pending");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> idx_ff <= batch_ff.top_idx)
      else $error("result index beyond the request's result count");

endmodule
`default_nettype wire

// ===== rtl/ber_oid_content_codec_unit.sv =====
// ber_oid_content_codec_unit: top level of the object identifier content codec
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  req_data  (boc_req_type)
//   rsp_     out        rsp_valid/rsp_stall  rsp_data  (boc_rsp_type)
//
// a request sits in the input register, then its results go to the result register;
// one request per cycle when it yields at most one result and rsp_stall stays low; a first
// content octet yields two results, an encoded arc 1 to 5 octets at 32-bit arcs (up to 6
// once ARC_BITS exceeds 35), one result per octet, as the result register sends one result
// a cycle while rsp_stall is low.
// reset is synchronous and clears both decoder and encoder state.
// rsp_stall holds the result register, and req_stall rises once the input register waits.
`default_nettype none
module ber_oid_content_codec_unit #(
   parameter int ARC_BITS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire boc_pkg::boc_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output boc_pkg::boc_rsp_type      rsp_data
);
   import boc_pkg::*;

   logic          in_valid_ff, in_valid_in;
   boc_req_type   in_ff, in_in;
   logic          produce;
   boc_batch_type batch;
   logic          emit_ready;
   logic          advance;
   logic          accept;

   // a request that yields no result leaves without waiting on the result side
   assign advance   = in_valid_ff && (!produce || emit_ready);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (accept) begin
         in_valid_in = 1'b1;
         in_in       = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_ff <= in_in;
   end

   boc_core #(
      .ARC_BITS(ARC_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .item    (in_ff),
      .produce (produce),
      .batch   (batch)
   );

   boc_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && produce),
      .batch     (batch),
      .rsp_stall (rsp_stall),
      .ready     (emit_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_held_request_stays: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_ff))
      else $error("waiting request lost or changed in input register");

endmodule
`default_nettype wire
